### rtl/ppu_background_dot_renderer_core_defines.svh
// Assertion macros used by the checker module of the background dot renderer.
`ifndef PPU_BACKGROUND_DOT_RENDERER_CORE_DEFINES_SVH
`define PPU_BACKGROUND_DOT_RENDERER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PPUBG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PPUBG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ppubg_pkg.sv
// Types and constants shared by the background dot renderer modules.
package ppubg_pkg;

    localparam int DOT_W         = 9;
    localparam int DOTS_PER_LINE = 341;
    localparam int VRAM_W        = 15;
    localparam int FETCH_ADDR_W  = 14;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 15;

    localparam logic [DOT_W-1:0] DOT_LAST        = DOT_W'(DOTS_PER_LINE - 1);
    localparam logic [DOT_W-1:0] DOT_VBL         = 9'd1;
    localparam logic [DOT_W-1:0] DOT_SHIFT_FIRST = 9'd2;
    localparam logic [DOT_W-1:0] DOT_Y_INC       = 9'd256;
    localparam logic [DOT_W-1:0] DOT_H_RELOAD    = 9'd257;
    localparam logic [DOT_W-1:0] DOT_V_FIRST     = 9'd280;
    localparam logic [DOT_W-1:0] DOT_V_LAST      = 9'd304;
    localparam logic [DOT_W-1:0] DOT_PRE_FIRST   = 9'd321;
    localparam logic [DOT_W-1:0] DOT_PRE_LAST    = 9'd337;
    localparam logic [DOT_W-1:0] DOT_NT_EXTRA    = 9'd338;
    localparam logic [DOT_W-1:0] DOT_ODD_SKIP    = 9'd339;
    localparam logic [DOT_W-1:0] VISIBLE_DOTS    = 9'd256;

    // Position of a dot inside the eight-dot fetch group.
    localparam logic [2:0] PHASE_NT    = 3'd0;
    localparam logic [2:0] PHASE_AT    = 3'd2;
    localparam logic [2:0] PHASE_PL    = 3'd4;
    localparam logic [2:0] PHASE_PH    = 3'd6;
    localparam logic [2:0] PHASE_INC_X = 3'd7;

    localparam logic [FETCH_ADDR_W-1:0] NT_BASE = 14'h2000;
    localparam logic [FETCH_ADDR_W-1:0] AT_BASE = 14'h23C0;

    typedef enum logic [2:0] {
        KIND_NT   = 3'd0,
        KIND_AT   = 3'd1,
        KIND_PL   = 3'd2,
        KIND_PH   = 3'd3,
        KIND_NONE = 3'd4
    } kind_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SHOW_BG   = 3'd0,
        CFG_SHOW_SPR  = 3'd1,
        CFG_PT_SEL    = 3'd2,
        CFG_NMI_EN    = 3'd3,
        CFG_FINE_X    = 3'd4,
        CFG_TEMP_ADDR = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic                    fetch_valid;
        logic [FETCH_ADDR_W-1:0] fetch_address;
        logic [1:0]              fetch_kind;
        logic                    pixel_valid;
        logic [7:0]              pixel_x;
        logic [7:0]              pixel_y;
        logic [3:0]              palette_index;
        logic                    vblank_flag;
        logic                    nmi_pulse;
        logic                    frame_done;
    } result_t;

endpackage

### rtl/ppubg_out_skid.sv
// Two-entry output register with skid slot for the renderer's result transfers.
module ppubg_out_skid
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ppubg_pkg::result_t  push_data,
    output logic                full,
    output logic                out_valid,
    input  logic                out_stall,
    output ppubg_pkg::result_t  out_data
);

    logic               main_valid_reg;
    logic               skid_valid_reg;
    ppubg_pkg::result_t main_reg;
    ppubg_pkg::result_t skid_reg;
    logic               take;

    assign take      = main_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= push;
            end
        end
        else if (push)
        begin
            if (main_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
    end

    // A push only happens while the skid slot is empty.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (skid_valid_reg)
            begin
                main_reg <= skid_reg;
            end
            else if (push)
            begin
                main_reg <= push_data;
            end
        end
        else if (push)
        begin
            if (main_valid_reg)
            begin
                skid_reg <= push_data;
            end
            else
            begin
                main_reg <= push_data;
            end
        end
    end

endmodule

### rtl/ppu_background_dot_renderer_core.sv
// Top level of the background dot renderer: timing counters, scroll address and shifters.
//
// Each input transfer is one video dot and carries the byte returned for the fetch
// requested on the previous dot. The block keeps the dot and line counters, the odd-frame
// bit, the 15-bit scroll address, the tile latches, the background shifters and the
// vblank flag, and for every dot it delivers exactly one result: the fetch it requests,
// the background pixel of visible dots, vblank, an NMI pulse and the end-of-frame mark.
// Rate: one dot per clock while in_stall is low. All work for a dot is a single pass of
// short logic from the state registers into the output register, so a new dot is
// taken unless stalled, and its result is registered. The output side has a main register
// and one skid slot; in_stall is a registered flag that rises only when both hold results,
// so a stalled consumer holds the input back after one extra dot has been absorbed.
// Configuration writes are always ready and must be made while no dot is in flight.
// LAST_LINE sets the last post-render line (260 for 262-line, up to 310 for 312-line
// timing) and with it the width of the line counter; the pre-render line is line minus one.
module ppu_background_dot_renderer_core
#(
    parameter int LAST_LINE = 260
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [7:0]                            read_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ppubg_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ppubg_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  fetch_valid,
    output logic [ppubg_pkg::FETCH_ADDR_W-1:0]    fetch_address,
    output logic [1:0]                            fetch_kind,
    output logic                                  pixel_valid,
    output logic [7:0]                            pixel_x,
    output logic [7:0]                            pixel_y,
    output logic [3:0]                            palette_index,
    output logic                                  vblank_flag,
    output logic                                  nmi_pulse,
    output logic                                  frame_done
);

    // The line counter holds the line number plus one, so the pre-render line is zero.
    localparam int LINE_W = $clog2(LAST_LINE + 2);
    localparam logic [LINE_W-1:0] LINE_PRE   = LINE_W'(0);
    localparam logic [LINE_W-1:0] LINE_POST  = LINE_W'(241);
    localparam logic [LINE_W-1:0] LINE_VBL   = LINE_W'(242);
    localparam logic [LINE_W-1:0] LINE_WRAP  = LINE_W'(LAST_LINE + 1);
    localparam logic [LINE_W-1:0] LINE_ONE   = LINE_W'(1);

    localparam int VW = ppubg_pkg::VRAM_W;
    localparam int AW = ppubg_pkg::FETCH_ADDR_W;

    // Configuration registers.
    logic          show_bg_reg;
    logic          show_spr_reg;
    logic          pt_sel_reg;
    logic          nmi_en_reg;
    logic [2:0]    fine_x_reg;
    logic [VW-1:0] temp_addr_reg;

    // Dot state.
    logic [ppubg_pkg::DOT_W-1:0] dot_reg,  dot_next;
    logic [LINE_W-1:0]           line_reg, line_next;
    logic                        odd_reg,  odd_next;
    logic [VW-1:0]               v_reg,    v_next;
    logic [7:0]                  nt_reg,   nt_next;
    logic [1:0]                  at_reg,   at_next;
    logic [7:0]                  pl_reg,   pl_next;
    logic [7:0]                  ph_reg,   ph_next;
    logic [15:0]                 pshift_reg [2];
    logic [15:0]                 pshift_next [2];
    logic [15:0]                 ashift_reg [2];
    logic [15:0]                 ashift_next [2];
    logic                        vblank_reg, vblank_next;
    ppubg_pkg::kind_t            pend_reg, pend_next;
    logic [1:0]                  quad_reg, quad_next;

    ppubg_pkg::result_t          result;
    ppubg_pkg::result_t          out_data;
    logic                        skid_full;
    logic                        in_accept;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_full;
    assign in_accept = in_valid && !skid_full;

    function automatic logic [VW-1:0] step_coarse_x(input logic [VW-1:0] v);
        logic [VW-1:0] r;
        if (v[4:0] == 5'h1F)
        begin
            r = (v & 15'h7FE0) ^ 15'h0400;
        end
        else
        begin
            r = v + 15'd1;
        end
        return r;
    endfunction

    function automatic logic [VW-1:0] step_y(input logic [VW-1:0] v);
        logic [VW-1:0] r;
        logic [4:0]    cy;
        logic          nt_y;
        cy   = v[9:5];
        nt_y = v[11];
        if (v[14:12] != 3'd7)
        begin
            r = v + 15'h1000;
        end
        else
        begin
            // Row 29 is the last tile row of a nametable; rows 30 and 31 hold attributes.
            if (cy == 5'd29)
            begin
                cy   = 5'd0;
                nt_y = ~nt_y;
            end
            else if (cy == 5'd31)
            begin
                cy = 5'd0;
            end
            else
            begin
                cy = cy + 5'd1;
            end
            r = {3'd0, nt_y, v[10], cy, v[4:0]};
        end
        return r;
    endfunction

    always_comb
    begin
        logic          rendering;
        logic          fetch_line;
        logic          pre_line;
        logic          region;
        logic [2:0]    phase;
        logic          fv;
        ppubg_pkg::kind_t fk;
        logic [AW-1:0] faddr;
        logic [AW-1:0] pat_addr;
        logic          nmi;
        logic          fdone;
        logic          skip;
        logic          wrap;
        logic          pv;
        logic [3:0]    bit_sel;
        logic [3:0]    pal;
        logic [LINE_W-1:0] row;

        nt_next     = nt_reg;
        at_next     = at_reg;
        pl_next     = pl_reg;
        ph_next     = ph_reg;
        pshift_next = pshift_reg;
        ashift_next = ashift_reg;
        v_next      = v_reg;
        vblank_next = vblank_reg;
        quad_next   = quad_reg;
        odd_next    = odd_reg;
        fv          = 1'b0;
        fk          = ppubg_pkg::KIND_NT;
        faddr       = '0;
        nmi         = 1'b0;
        fdone       = 1'b0;

        // Store the byte of the previous dot's fetch first.
        case (pend_reg)
            ppubg_pkg::KIND_NT: nt_next = read_data;
            ppubg_pkg::KIND_AT:
            begin
                case (quad_reg)
                    2'd0:    at_next = read_data[1:0];
                    2'd1:    at_next = read_data[3:2];
                    2'd2:    at_next = read_data[5:4];
                    default: at_next = read_data[7:6];
                endcase
            end
            ppubg_pkg::KIND_PL: pl_next = read_data;
            ppubg_pkg::KIND_PH: ph_next = read_data;
            default: ;
        endcase

        rendering  = show_bg_reg | show_spr_reg;
        fetch_line = line_reg < LINE_POST;
        pre_line   = line_reg == LINE_PRE;
        region     = (dot_reg >= ppubg_pkg::DOT_SHIFT_FIRST && dot_reg <= ppubg_pkg::DOT_H_RELOAD)
                  || (dot_reg >= ppubg_pkg::DOT_PRE_FIRST && dot_reg <= ppubg_pkg::DOT_PRE_LAST);
        phase      = dot_reg[2:0] - 3'd1;
        pat_addr   = {1'b0, pt_sel_reg, nt_next, 1'b0, v_reg[14:12]};

        if (fetch_line)
        begin
            if (region)
            begin
                if (show_bg_reg)
                begin
                    for (int i = 0; i < 2; i++)
                    begin
                        pshift_next[i] = {pshift_reg[i][14:0], 1'b0};
                        ashift_next[i] = {ashift_reg[i][14:0], 1'b0};
                    end
                end
                case (phase)
                    ppubg_pkg::PHASE_NT:
                    begin
                        pshift_next[0] = {pshift_next[0][15:8], pl_next};
                        pshift_next[1] = {pshift_next[1][15:8], ph_next};
                        ashift_next[0] = {ashift_next[0][15:8], {8{at_next[0]}}};
                        ashift_next[1] = {ashift_next[1][15:8], {8{at_next[1]}}};
                        fv    = 1'b1;
                        fk    = ppubg_pkg::KIND_NT;
                        faddr = ppubg_pkg::NT_BASE | {2'b00, v_reg[11:0]};
                    end
                    ppubg_pkg::PHASE_AT:
                    begin
                        fv        = 1'b1;
                        fk        = ppubg_pkg::KIND_AT;
                        faddr     = ppubg_pkg::AT_BASE | {2'b00, v_reg[11:10], 10'd0}
                                  | {8'd0, v_reg[9:7], 3'd0} | {11'd0, v_reg[4:2]};
                        quad_next = {v_reg[6], v_reg[1]};
                    end
                    ppubg_pkg::PHASE_PL:
                    begin
                        fv    = 1'b1;
                        fk    = ppubg_pkg::KIND_PL;
                        faddr = pat_addr;
                    end
                    ppubg_pkg::PHASE_PH:
                    begin
                        fv    = 1'b1;
                        fk    = ppubg_pkg::KIND_PH;
                        faddr = pat_addr | 14'h0008;
                    end
                    ppubg_pkg::PHASE_INC_X:
                    begin
                        if (rendering)
                        begin
                            v_next = step_coarse_x(v_reg);
                        end
                    end
                    default: ;
                endcase
                if (rendering && dot_reg == ppubg_pkg::DOT_Y_INC)
                begin
                    v_next = step_y(v_next);
                end
                if (rendering && dot_reg == ppubg_pkg::DOT_H_RELOAD)
                begin
                    v_next = (v_next & 15'h7BE0) | (temp_addr_reg & 15'h041F);
                end
            end
            else if (dot_reg == ppubg_pkg::DOT_NT_EXTRA || dot_reg == ppubg_pkg::DOT_LAST)
            begin
                fv    = 1'b1;
                fk    = ppubg_pkg::KIND_NT;
                faddr = ppubg_pkg::NT_BASE | {2'b00, v_reg[11:0]};
            end
            if (pre_line)
            begin
                if (dot_reg == ppubg_pkg::DOT_VBL)
                begin
                    vblank_next = 1'b0;
                end
                if (rendering && dot_reg >= ppubg_pkg::DOT_V_FIRST
                    && dot_reg <= ppubg_pkg::DOT_V_LAST)
                begin
                    v_next = (v_next & 15'h041F) | (temp_addr_reg & 15'h7BE0);
                end
            end
        end
        else if (line_reg == LINE_VBL && dot_reg == ppubg_pkg::DOT_VBL)
        begin
            vblank_next = 1'b1;
            nmi         = nmi_en_reg;
        end

        // Pixel from the shifters after this dot's shift and load.
        pv      = show_bg_reg && dot_reg < ppubg_pkg::VISIBLE_DOTS
               && line_reg != LINE_PRE && fetch_line;
        bit_sel = 4'd15 - {1'b0, fine_x_reg};
        pal     = {ashift_next[1][bit_sel], ashift_next[0][bit_sel],
                   pshift_next[1][bit_sel], pshift_next[0][bit_sel]};
        row     = line_reg - LINE_ONE;

        pend_next = fv ? fk : ppubg_pkg::KIND_NONE;

        // On the pre-render line of an odd frame the idle dot at the end is skipped.
        skip = pre_line && odd_reg && dot_reg == ppubg_pkg::DOT_ODD_SKIP;
        wrap = skip || dot_reg == ppubg_pkg::DOT_LAST;
        if (wrap)
        begin
            dot_next = '0;
            if (line_reg == LINE_WRAP)
            begin
                line_next = LINE_PRE;
                fdone     = 1'b1;
                odd_next  = ~odd_reg;
            end
            else
            begin
                line_next = line_reg + LINE_ONE;
            end
        end
        else
        begin
            dot_next  = dot_reg + 9'd1;
            line_next = line_reg;
        end

        result.fetch_valid   = fv;
        result.fetch_address = faddr;
        result.fetch_kind    = fv ? 2'(fk) : 2'd0;
        result.pixel_valid   = pv;
        result.pixel_x       = pv ? dot_reg[7:0] : 8'd0;
        result.pixel_y       = pv ? row[7:0] : 8'd0;
        result.palette_index = pv ? pal : 4'd0;
        result.vblank_flag   = vblank_next;
        result.nmi_pulse     = nmi;
        result.frame_done    = fdone;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg       <= '0;
            line_reg      <= LINE_PRE;
            odd_reg       <= 1'b0;
            v_reg         <= '0;
            nt_reg        <= '0;
            at_reg        <= '0;
            pl_reg        <= '0;
            ph_reg        <= '0;
            pshift_reg[0] <= '0;
            pshift_reg[1] <= '0;
            ashift_reg[0] <= '0;
            ashift_reg[1] <= '0;
            vblank_reg    <= 1'b0;
            pend_reg      <= ppubg_pkg::KIND_NONE;
            quad_reg      <= '0;
        end
        else if (in_accept)
        begin
            dot_reg    <= dot_next;
            line_reg   <= line_next;
            odd_reg    <= odd_next;
            v_reg      <= v_next;
            nt_reg     <= nt_next;
            at_reg     <= at_next;
            pl_reg     <= pl_next;
            ph_reg     <= ph_next;
            pshift_reg <= pshift_next;
            ashift_reg <= ashift_next;
            vblank_reg <= vblank_next;
            pend_reg   <= pend_next;
            quad_reg   <= quad_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            show_bg_reg   <= 1'b0;
            show_spr_reg  <= 1'b0;
            pt_sel_reg    <= 1'b0;
            nmi_en_reg    <= 1'b0;
            fine_x_reg    <= '0;
            temp_addr_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (ppubg_pkg::cfg_reg_t'(cfg_index))
                ppubg_pkg::CFG_SHOW_BG:   show_bg_reg   <= cfg_data[0];
                ppubg_pkg::CFG_SHOW_SPR:  show_spr_reg  <= cfg_data[0];
                ppubg_pkg::CFG_PT_SEL:    pt_sel_reg    <= cfg_data[0];
                ppubg_pkg::CFG_NMI_EN:    nmi_en_reg    <= cfg_data[0];
                ppubg_pkg::CFG_FINE_X:    fine_x_reg    <= cfg_data[2:0];
                ppubg_pkg::CFG_TEMP_ADDR: temp_addr_reg <= cfg_data[VW-1:0];
                default: ;
            endcase
        end
    end

    ppubg_out_skid u_out_skid
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_accept),
        .push_data (result),
        .full      (skid_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign fetch_valid   = out_data.fetch_valid;
    assign fetch_address = out_data.fetch_address;
    assign fetch_kind    = out_data.fetch_kind;
    assign pixel_valid   = out_data.pixel_valid;
    assign pixel_x       = out_data.pixel_x;
    assign pixel_y       = out_data.pixel_y;
    assign palette_index = out_data.palette_index;
    assign vblank_flag   = out_data.vblank_flag;
    assign nmi_pulse     = out_data.nmi_pulse;
    assign frame_done    = out_data.frame_done;

endmodule

### rtl/ppubg_checker.sv
// Port-level checker for the background dot renderer and its bind statement.
`include "ppu_background_dot_renderer_core_defines.svh"

module ppubg_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic                                fetch_valid,
    input logic [ppubg_pkg::FETCH_ADDR_W-1:0]  fetch_address,
    input logic [1:0]                          fetch_kind,
    input logic                                pixel_valid,
    input logic [7:0]                          pixel_x,
    input logic [7:0]                          pixel_y,
    input logic [3:0]                          palette_index,
    input logic                                vblank_flag,
    input logic                                nmi_pulse
);

    // A held result keeps its fetch request.
    `PPUBG_ASSERT_NEXT(a_hold_fetch, clk, rst_n, out_valid && out_stall, out_valid && $stable(fetch_valid) && $stable(fetch_address) && $stable(fetch_kind), "stalled result changed")

    `PPUBG_ASSERT_SAME(a_idle_fetch, clk, rst_n, out_valid && !fetch_valid, fetch_address == 14'd0 && fetch_kind == 2'd0, "fetch fields set without a fetch")

    `PPUBG_ASSERT_SAME(a_idle_pixel, clk, rst_n, out_valid && !pixel_valid, pixel_x == 8'd0 && pixel_y == 8'd0 && palette_index == 4'd0, "pixel fields set without a pixel")

    `PPUBG_ASSERT_SAME(a_row_range, clk, rst_n, out_valid && pixel_valid, pixel_y < 8'd240, "pixel row out of range")

    `PPUBG_ASSERT_SAME(a_nmi_vblank, clk, rst_n, out_valid && nmi_pulse, vblank_flag && !pixel_valid && !fetch_valid, "NMI without vblank")

endmodule

bind ppu_background_dot_renderer_core ppubg_checker u_ppubg_checker (.*);

### test/ppubg_dot_check_pkg.sv
// Scoreboard that predicts and checks every dot of the background dot renderer.
package ppubg_dot_check_pkg;
    import ppubg_pkg::*;

    class dot_scoreboard;
        // Register copy.
        bit        show_bg;
        bit        show_spr;
        bit        pt_sel;
        bit        nmi_en;
        bit [2:0]  fine_x;
        bit [14:0] temp_addr;

        // Renderer state copy.
        int        last_line;
        bit [8:0]  dot_no;
        int        line_no;
        bit        odd_frame;
        bit [14:0] vaddr;
        bit [7:0]  tile_latch;
        bit [7:0]  pat_lo_latch;
        bit [7:0]  pat_hi_latch;
        bit [1:0]  attr_latch;
        bit [1:0]  attr_quad;
        bit [15:0] pat_shift [2];
        bit [15:0] attr_shift [2];
        bit        vblank;
        kind_t     pending;

        result_t   dot_results_due [$];

        int        failures;
        int        results_checked;
        int        dots_noted;
        int        pixels;
        int        fetches;
        int        frame_ends;
        int        nmi_pulses;
        int        odd_skips;
        int        reg_writes;

        function new(int last_line);
            this.last_line = last_line;
            line_no = -1;
            pending = KIND_NONE;
        endfunction

        function int outstanding();
            return dot_results_due.size();
        endfunction

        function bit rendering();
            return show_bg | show_spr;
        endfunction

        function void load_shifters();
            pat_shift[0]  = {pat_shift[0][15:8], pat_lo_latch};
            pat_shift[1]  = {pat_shift[1][15:8], pat_hi_latch};
            attr_shift[0] = {attr_shift[0][15:8], {8{attr_latch[0]}}};
            attr_shift[1] = {attr_shift[1][15:8], {8{attr_latch[1]}}};
        endfunction

        function bit [13:0] pattern_addr();
            return (14'(pt_sel) << 12) + (14'(tile_latch) << 4) + 14'(vaddr[14:12]);
        endfunction

        function void set_register(bit [2:0] index, bit [14:0] value);
            reg_writes++;
            case (index)
                CFG_SHOW_BG:   show_bg   = value[0];
                CFG_SHOW_SPR:  show_spr  = value[0];
                CFG_PT_SEL:    pt_sel    = value[0];
                CFG_NMI_EN:    nmi_en    = value[0];
                CFG_FINE_X:    fine_x    = value[2:0];
                CFG_TEMP_ADDR: temp_addr = value;
                default: ;
            endcase
        endfunction

        // Advance the copy by one dot and queue the result it must produce.
        function void note_dot(bit [7:0] data);
            result_t   r;
            int        dot;
            int        line;
            int        sh;
            bit        fv;
            kind_t     fkind;
            bit [13:0] faddr;
            bit [4:0]  coarse_y;
            r     = '0;
            fv    = 1'b0;
            fkind = KIND_NT;
            faddr = '0;
            dot   = dot_no;
            line  = line_no;
            dots_noted++;

            // The byte lands in the latch of the fetch issued on the previous dot.
            case (pending)
                KIND_NT: tile_latch   = data;
                KIND_AT: attr_latch   = 2'(data >> (2 * attr_quad));
                KIND_PL: pat_lo_latch = data;
                KIND_PH: pat_hi_latch = data;
                default: ;
            endcase
            pending = KIND_NONE;

            if (line < 240) begin
                if ((dot >= 2 && dot <= 257) || (dot >= 321 && dot <= 337)) begin
                    if (show_bg) begin
                        pat_shift[0]  = pat_shift[0] << 1;
                        pat_shift[1]  = pat_shift[1] << 1;
                        attr_shift[0] = attr_shift[0] << 1;
                        attr_shift[1] = attr_shift[1] << 1;
                    end
                    case (3'(dot - 1))
                        PHASE_NT: begin
                            load_shifters();
                            fv    = 1'b1;
                            fkind = KIND_NT;
                            faddr = NT_BASE | 14'(vaddr[11:0]);
                        end
                        PHASE_AT: begin
                            fv    = 1'b1;
                            fkind = KIND_AT;
                            faddr = AT_BASE | 14'(vaddr & 15'h0C00)
                                  | 14'((vaddr >> 4) & 15'h0038) | 14'((vaddr >> 2) & 15'h0007);
                            attr_quad = {vaddr[6], vaddr[1]};
                        end
                        PHASE_PL: begin
                            fv    = 1'b1;
                            fkind = KIND_PL;
                            faddr = pattern_addr();
                        end
                        PHASE_PH: begin
                            fv    = 1'b1;
                            fkind = KIND_PH;
                            faddr = pattern_addr() + 14'd8;
                        end
                        PHASE_INC_X: begin
                            if (rendering()) begin
                                if (vaddr[4:0] == 5'h1F)
                                    vaddr = (vaddr & 15'h7FE0) ^ 15'h0400;
                                else
                                    vaddr = vaddr + 15'd1;
                            end
                        end
                        default: ;
                    endcase
                    if (dot == DOT_Y_INC) begin
                        if (rendering()) begin
                            if (vaddr[14:12] < 3'd7) begin
                                vaddr = vaddr + 15'h1000;
                            end
                            else begin
                                vaddr    = vaddr & 15'h0FFF;
                                coarse_y = vaddr[9:5];
                                if (coarse_y == 5'd29) begin
                                    coarse_y = 5'd0;
                                    vaddr    = vaddr ^ 15'h0800;
                                end
                                else if (coarse_y == 5'd31) begin
                                    coarse_y = 5'd0;
                                end
                                else begin
                                    coarse_y = coarse_y + 5'd1;
                                end
                                vaddr = (vaddr & 15'h7C1F) | {5'd0, coarse_y, 5'd0};
                            end
                        end
                    end
                    else if (dot == DOT_H_RELOAD) begin
                        load_shifters();
                        if (rendering())
                            vaddr = (vaddr & 15'h7BE0) | (temp_addr & 15'h041F);
                    end
                end
                else if (dot == DOT_NT_EXTRA || dot == DOT_LAST) begin
                    fv    = 1'b1;
                    fkind = KIND_NT;
                    faddr = NT_BASE | 14'(vaddr[11:0]);
                end
                if (line == -1) begin
                    if (dot == DOT_VBL)
                        vblank = 1'b0;
                    if (dot >= DOT_V_FIRST && dot <= DOT_V_LAST && rendering())
                        vaddr = (vaddr & 15'h041F) | (temp_addr & 15'h7BE0);
                    if (dot == DOT_ODD_SKIP && odd_frame) begin
                        dot++;
                        odd_skips++;
                    end
                end
            end
            else if (line == 241 && dot == DOT_VBL) begin
                vblank      = 1'b1;
                r.nmi_pulse = nmi_en;
            end

            if (show_bg && dot_no < VISIBLE_DOTS && line >= 0 && line < 240) begin
                sh              = 15 - fine_x;
                r.pixel_valid   = 1'b1;
                r.pixel_x       = dot_no[7:0];
                r.pixel_y       = 8'(line);
                r.palette_index = {attr_shift[1][sh], attr_shift[0][sh],
                                   pat_shift[1][sh], pat_shift[0][sh]};
                pixels++;
            end

            if (fv) begin
                pending = fkind;
                fetches++;
            end

            dot++;
            if (dot > DOT_LAST) begin
                dot = 0;
                line++;
                if (line > last_line) begin
                    line         = -1;
                    r.frame_done = 1'b1;
                    odd_frame    = ~odd_frame;
                    frame_ends++;
                end
            end
            dot_no  = 9'(dot);
            line_no = line;

            r.fetch_valid   = fv;
            r.fetch_address = faddr;
            r.fetch_kind    = 2'(fkind);
            r.vblank_flag   = vblank;
            if (r.nmi_pulse)
                nmi_pulses++;
            dot_results_due.push_back(r);
        endfunction

        function void check_field(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                failures++;
                if (failures <= 10)
                    $display("Mismatch on result %0d, %s: expected 0x%0h, got 0x%0h",
                             results_checked, field, want, got);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (dot_results_due.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("Result 0x%0h arrived with no dot waiting for it", got);
                return;
            end
            want = dot_results_due.pop_front();
            check_field("fetch_valid", want.fetch_valid, got.fetch_valid);
            check_field("fetch_address", want.fetch_address, got.fetch_address);
            check_field("fetch_kind", want.fetch_kind, got.fetch_kind);
            check_field("pixel_valid", want.pixel_valid, got.pixel_valid);
            check_field("pixel_x", want.pixel_x, got.pixel_x);
            check_field("pixel_y", want.pixel_y, got.pixel_y);
            check_field("palette_index", want.palette_index, got.palette_index);
            check_field("vblank_flag", want.vblank_flag, got.vblank_flag);
            check_field("nmi_pulse", want.nmi_pulse, got.nmi_pulse);
            check_field("frame_done", want.frame_done, got.frame_done);
            results_checked++;
        endfunction
    endclass

endpackage

### test/tb_ppu_background_dot_renderer_core.sv
// Self-checking testbench of the background dot renderer over the first lines of a frame.
module tb_ppu_background_dot_renderer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ppubg_pkg::*;
    import ppubg_dot_check_pkg::*;

    localparam int LAST_LINE   = 260;
    localparam int CLK_PERIOD  = 2;
    // Enough dots to cover the pre-render line with its vertical scroll reload and the
    // first visible lines with their fetches, pixels and scroll increments.
    localparam int TOTAL_DOTS  = 1300;
    // Far above the slowest legal run, in which both sides keep idling.
    localparam int CYCLE_LIMIT = TOTAL_DOTS * 12 + 50000;
    localparam int HOLD_CYCLES = 200;
    localparam int IDLE_PCT    = 27;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [7:0]              read_data;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    out_valid;
    logic                    out_stall;
    logic                    fetch_valid;
    logic [FETCH_ADDR_W-1:0] fetch_address;
    logic [1:0]              fetch_kind;
    logic                    pixel_valid;
    logic [7:0]              pixel_x;
    logic [7:0]              pixel_y;
    logic [3:0]              palette_index;
    logic                    vblank_flag;
    logic                    nmi_pulse;
    logic                    frame_done;

    result_t       observed;
    dot_scoreboard sb;
    int            dots_sent;
    int            cycle_count;
    int            send_idle_pct;
    int            stall_pct;
    bit            hold_request;
    int            phase;
    int            chunk;

    // Directed bytes: both extremes, walking ones and zeros, and alternating patterns.
    localparam logic [7:0] DIRECTED_BYTES [24] = '{
        8'h00, 8'hFF, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20,
        8'h40, 8'h80, 8'hFE, 8'hFD, 8'hFB, 8'hF7, 8'hEF, 8'hDF,
        8'hBF, 8'h7F, 8'hAA, 8'h55, 8'h0F, 8'hF0, 8'hCC, 8'h33
    };

    ppu_background_dot_renderer_core #(
        .LAST_LINE(LAST_LINE)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .read_data    (read_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .fetch_valid  (fetch_valid),
        .fetch_address(fetch_address),
        .fetch_kind   (fetch_kind),
        .pixel_valid  (pixel_valid),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .palette_index(palette_index),
        .vblank_flag  (vblank_flag),
        .nmi_pulse    (nmi_pulse),
        .frame_done   (frame_done)
    );

    // The output ports gathered in the field order of the package's result struct.
    assign observed = {fetch_valid, fetch_address, fetch_kind, pixel_valid, pixel_x,
                       pixel_y, palette_index, vblank_flag, nmi_pulse, frame_done};

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // Every transfer is seen at the rising edge, where all inputs were set at the falling
    // edge before it and the block's registered outputs still hold their pre-edge values.
    // A register write updates the predictor's copy, an input transfer advances the
    // predictor by one dot, and an output transfer is checked against the oldest dot.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.set_register(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                sb.note_dot(read_data);
            if (out_valid && !out_stall)
                sb.check_result(observed);
        end
    end

    // Receiver. It stalls at random at the falling edge. When asked for a hold-off it
    // keeps the stall high long enough that the output register and the skid slot
    // both fill and the block stalls its input.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Run stopped after %0d cycles with %0d results still due",
                 cycle_count, sb.outstanding());
        $display("tb_ppu_background_dot_renderer_core failed");
        $finish;
    end

    // Offer one dot. Idle cycles come before the offer, never while a dot is waiting,
    // so valid does not depend on stall and a stalled byte stays put.
    task automatic send_dot(input logic [7:0] value);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        read_data <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        dots_sent++;
    endtask

    // Stop offering dots and wait until every expected result has been transferred.
    // The check is made at the falling edge, after all rising-edge work is done.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(negedge clk);
    endtask

    task automatic write_register(input logic [2:0] index, input logic [14:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Register settings for one phase. The first phases walk through the extremes:
    // largest fine scroll and scroll address, sprites alone keeping the scroll logic
    // running without pixels, rendering fully off, then background and sprites on with the rest at zero.
    // Later phases rewrite a random subset, unused indexes included.
    task automatic configure_phase(input int phase_no);
        logic [14:0] value;
        case (phase_no)
            0:
            begin
                write_register(CFG_FINE_X, 15'd7);
                write_register(CFG_TEMP_ADDR, 15'h7FFF);
                write_register(CFG_PT_SEL, 15'd1);
            end
            1:
            begin
                write_register(CFG_SHOW_BG, 15'd0);
                write_register(CFG_SHOW_SPR, 15'd1);
            end
            2:
            begin
                write_register(CFG_SHOW_SPR, 15'd0);
                write_register(CFG_NMI_EN, 15'd0);
            end
            3:
            begin
                write_register(CFG_SHOW_BG, 15'd1);
                write_register(CFG_SHOW_SPR, 15'd1);
                write_register(CFG_FINE_X, 15'd0);
                write_register(CFG_TEMP_ADDR, 15'd0);
                write_register(CFG_PT_SEL, 15'd0);
            end
            default:
            begin
                for (int idx = 0; idx < 8; idx++)
                begin
                    if ($urandom_range(0, 99) < 35)
                    begin
                        value = 15'($urandom);
                        if (3'(idx) == CFG_SHOW_BG)
                            value[0] = ($urandom_range(0, 99) < 75);
                        if (3'(idx) == CFG_TEMP_ADDR)
                        begin
                            case ($urandom_range(0, 4))
                                0:       value = 15'h0000;
                                1:       value = 15'h7FFF;
                                default: ;
                            endcase
                        end
                        write_register(3'(idx), value);
                    end
                end
            end
        endcase
        // Make sure the start of vblank is met with the NMI armed.
        if (sb.line_no >= 228 && sb.line_no <= 240)
            write_register(CFG_NMI_EN, 15'd1);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        read_data     = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        dots_sent     = 0;
        send_idle_pct = IDLE_PCT;
        stall_pct     = IDLE_PCT;
        hold_request  = 1'b0;
        sb            = new(LAST_LINE);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed start on the pre-render line: background on, NMI armed, and the
        // fetch latches fed with the extreme byte patterns.
        write_register(CFG_SHOW_BG, 15'd1);
        write_register(CFG_SHOW_SPR, 15'd0);
        write_register(CFG_PT_SEL, 15'd0);
        write_register(CFG_NMI_EN, 15'd1);
        write_register(CFG_FINE_X, 15'd0);
        write_register(CFG_TEMP_ADDR, 15'h0000);
        foreach (DIRECTED_BYTES[i])
            send_dot(DIRECTED_BYTES[i]);

        // Random phases, each a stretch of consecutive dots with random bytes. Settings
        // change only between phases, once the block has delivered every result.
        phase = 0;
        while (dots_sent < TOTAL_DOTS)
        begin
            drain();
            configure_phase(phase);
            if (phase == 4)
                hold_request = 1'b1;
            if (phase == 6)
            begin
                send_idle_pct = 0;
                stall_pct     = 0;
                chunk         = 250;
            end
            else
            begin
                send_idle_pct = IDLE_PCT;
                stall_pct     = IDLE_PCT;
                chunk         = $urandom_range(80, 150);
            end
            if (chunk > TOTAL_DOTS - dots_sent)
                chunk = TOTAL_DOTS - dots_sent;
            repeat (chunk)
                send_dot(8'($urandom));
            phase++;
        end

        drain();
        // Waiting on past the drain catches any result beyond the last expected one.
        repeat (8) @(posedge clk);

        $display("Covered %0d dots and %0d frame ends: %0d pixels, %0d fetches,",
                 sb.dots_noted, sb.frame_ends, sb.pixels, sb.fetches);
        $display("%0d register writes over %0d phases, %0d results checked, %0d failures",
                 sb.reg_writes, phase, sb.results_checked, sb.failures);
        if (sb.failures == 0)
            $display("tb_ppu_background_dot_renderer_core passed");
        else
            $display("tb_ppu_background_dot_renderer_core failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/ppubg_pkg.sv
rtl/ppubg_out_skid.sv
rtl/ppu_background_dot_renderer_core.sv
rtl/ppubg_checker.sv
test/ppubg_dot_check_pkg.sv
test/tb_ppu_background_dot_renderer_core.sv
